/* src/tppr_pkg.sv */
// ----------------------------------------------------------------------------
// tppr_pkg
// Shared constants, widths and register codes of the three-phase power
// regulator.
// ----------------------------------------------------------------------------
package tppr_pkg;

  // Power below this request is treated as a request for no power at all.
  localparam int unsigned MIN_POWER = 50;
  // Number of mains phases handled in rotation.
  localparam int unsigned PHASES = 3;
  // Angle offset below the floor used while the regulator is switched off.
  localparam int unsigned OFF_DELTA = 500;

  localparam int SUM_W   = 40;  // squared sum
  localparam int RATIO_W = 24;  // Q8.16 scale factor
  localparam int VAL_W   = 16;  // RMS values, powers, angles
  localparam int TOTAL_W = 18;  // sum of three phase powers
  localparam int ROOT_W  = 20;  // square root of a 40-bit quotient
  localparam int REM_W   = 21;  // partial remainder of the root
  localparam int SUB_W   = 23;  // shared compare-subtract unit
  localparam int MUL_W   = 24;  // shared multiplier operands
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_COUNT  = 4'd0,
    REG_CURRENT_RATIO = 4'd1,
    REG_VOLTAGE_RATIO = 4'd2,
    REG_POWER_TARGET  = 4'd3,
    REG_POWER_MAX     = 4'd4,
    REG_LOOP_LAG      = 4'd5,
    REG_ANGLE_FLOOR   = 4'd6,
    REG_ANGLE_CEILING = 4'd7
  } cfg_reg_t;

endpackage

/* src/three_phase_power_regulator_unit.sv */
// ----------------------------------------------------------------------------
// three_phase_power_regulator_unit
// RMS measurement, phase power and integral firing-angle control for a
// three-phase triac regulator.
// ----------------------------------------------------------------------------
// Each input transaction carries one finished sum of squared ADC samples.
// Windows alternate current then voltage for phase 0, 1 and 2 in turn; the
// result transaction reports the RMS value of the window in Q10.6 and, after
// a voltage window, the phase power, the three-phase total, the new firing
// angle and the running average power. The block works on one window at a
// time: in_stall is high from acceptance until the result has been loaded
// into the output register, which then holds it until the consumer takes it.
// The time a window takes is set almost entirely by the single bit-serial
// compare-subtract unit: 40 steps to divide the sum by the sample count, 20
// steps for the square root, and for voltage windows 18 more steps to divide
// the power error by the loop lag. One shared 24x24 multiplier forms the
// scaled RMS value and the phase power. Configuration transactions are
// always accepted and should be issued only while no window is in flight.
// ----------------------------------------------------------------------------
module three_phase_power_regulator_unit (
  input  logic                              clk,
  input  logic                              rst,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tppr_pkg::SUM_W-1:0]        square_sum,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              was_voltage,
  output logic [1:0]                        phase_index,
  output logic [tppr_pkg::VAL_W-1:0]        rms_value,
  output logic [tppr_pkg::VAL_W-1:0]        phase_power,
  output logic [tppr_pkg::TOTAL_W-1:0]      total_power,
  output logic [tppr_pkg::VAL_W-1:0]        fire_angle,
  output logic [tppr_pkg::VAL_W-1:0]        average_power,
  output logic                              next_is_voltage,
  output logic [1:0]                        next_phase,
  // Configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tppr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tppr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SQRT, S_MUL_RMS, S_RMS, S_MUL_PWR, S_PWR,
    S_ERR, S_DIV_ERR, S_ANGLE, S_WRAP, S_DONE
  } state_t;

  localparam logic [5:0] SUM_STEPS_LAST  = 6'(tppr_pkg::SUM_W - 1);
  localparam logic [5:0] ROOT_STEPS_LAST = 6'(tppr_pkg::ROOT_W - 1);
  localparam logic [5:0] ERR_STEPS_LAST  = 6'(tppr_pkg::TOTAL_W - 1);
  localparam logic [1:0] LAST_PHASE      = 2'(tppr_pkg::PHASES - 1);
  localparam logic [15:0] MIN_POWER_V    = 16'(tppr_pkg::MIN_POWER);
  localparam logic [15:0] OFF_DELTA_V    = 16'(tppr_pkg::OFF_DELTA);
  localparam logic [15:0] VAL_MAX        = '1;

  // Configuration registers.
  logic [15:0] sample_count;
  logic [23:0] current_ratio;
  logic [23:0] voltage_ratio;
  logic [15:0] power_target;
  logic [15:0] power_max;
  logic [15:0] loop_lag;
  logic [15:0] angle_floor;
  logic [15:0] angle_ceiling;

  // Regulator state.
  state_t      state;
  logic        measure_voltage;
  logic [1:0]  phase_counter;
  logic [15:0] current_rms [3];
  logic [15:0] phase_powers [3];
  logic [15:0] angle_acc;
  logic [15:0] power_average;

  // Working registers of the sequencer.
  logic        was_v;
  logic [1:0]  ph;
  logic [5:0]  step;
  logic [39:0] work;      // dividend, then quotient, then radicand
  logic [20:0] rem;
  logic [19:0] root;
  logic [15:0] divisor;
  logic [47:0] prod;
  logic [15:0] rms;
  logic [15:0] pp;
  logic        err_neg;

  // Shared compare-subtract unit.
  logic [tppr_pkg::SUB_W-1:0] sub_a;
  logic [tppr_pkg::SUB_W-1:0] sub_b;
  logic [tppr_pkg::SUB_W:0]   sub_diff;
  logic                       sub_ge;

  // Shared multiplier.
  logic [tppr_pkg::MUL_W-1:0] mul_a;
  logic [tppr_pkg::MUL_W-1:0] mul_b;

  logic [15:0] rms_sat;
  logic [15:0] pp_sat;
  logic [17:0] total;
  logic [15:0] target;
  logic [18:0] err;
  logic [17:0] err_mag;
  logic [19:0] angle_step;
  logic [19:0] angle_sum;
  logic [15:0] angle_clamped;
  logic [18:0] avg_sum;
  logic [17:0] avg_half;
  logic [15:0] avg_sat;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state)
      S_DIV, S_DIV_ERR: begin
        sub_a = {6'd0, rem[15:0], work[39]};
        sub_b = {7'd0, divisor};
      end
      S_SQRT: begin
        sub_a = {rem, work[39:38]};
        sub_b = {1'b0, root, 2'b01};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    sub_ge   = ~sub_diff[tppr_pkg::SUB_W];
  end

  always_comb begin
    if (state == S_MUL_PWR) begin
      mul_a = {8'd0, current_rms[ph]};
      mul_b = {8'd0, rms};
    end else begin
      mul_a = {4'd0, root};
      mul_b = was_v ? voltage_ratio : current_ratio;
    end
  end

  always_comb begin
    // RMS = (root * ratio) >> 10, saturated; power = (I * U) >> 12, saturated.
    rms_sat = (|prod[47:26]) ? VAL_MAX : prod[25:10];
    pp_sat  = (|prod[47:28]) ? VAL_MAX : prod[27:12];

    total = {2'd0, phase_powers[0]} + {2'd0, phase_powers[1]} + {2'd0, phase_powers[2]};

    if (power_target > power_max) begin
      target = power_max;
    end else if (power_target < MIN_POWER_V) begin
      target = '0;
    end else begin
      target = power_target;
    end

    err     = {3'd0, target} - {1'b0, total};
    err_mag = err[18] ? 18'(-err) : err[17:0];

    // The quotient is a magnitude; apply the sign of the error afterwards so
    // the division truncates toward zero.
    angle_step = err_neg ? -{2'd0, work[17:0]} : {2'd0, work[17:0]};
    angle_sum  = {4'd0, angle_acc} + angle_step;
    if ($signed(angle_sum) < $signed({4'd0, angle_floor})) begin
      angle_clamped = angle_floor;
    end else if ($signed(angle_sum) > $signed({4'd0, angle_ceiling})) begin
      angle_clamped = angle_ceiling;
    end else begin
      angle_clamped = angle_sum[15:0];
    end

    avg_sum  = {3'd0, power_average} + {1'b0, total};
    avg_half = avg_sum[18:1];
    avg_sat  = (|avg_half[17:16]) ? VAL_MAX : avg_half[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      sample_count    <= 16'd1;
      current_ratio   <= 24'd65536;
      voltage_ratio   <= 24'd65536;
      power_target    <= 16'd0;
      power_max       <= 16'd65535;
      loop_lag        <= 16'd1;
      angle_floor     <= 16'd0;
      angle_ceiling   <= 16'd65535;
      measure_voltage <= 1'b0;
      phase_counter   <= 2'd0;
      angle_acc       <= '0;
      power_average   <= '0;
      for (int i = 0; i < 3; i++) begin
        current_rms[i]  <= '0;
        phase_powers[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tppr_pkg::REG_SAMPLE_COUNT:  sample_count  <= cfg_data[15:0];
          tppr_pkg::REG_CURRENT_RATIO: current_ratio <= cfg_data;
          tppr_pkg::REG_VOLTAGE_RATIO: voltage_ratio <= cfg_data;
          tppr_pkg::REG_POWER_TARGET:  power_target  <= cfg_data[15:0];
          tppr_pkg::REG_POWER_MAX:     power_max     <= cfg_data[15:0];
          tppr_pkg::REG_LOOP_LAG:      loop_lag      <= cfg_data[15:0];
          tppr_pkg::REG_ANGLE_FLOOR:   angle_floor   <= cfg_data[15:0];
          tppr_pkg::REG_ANGLE_CEILING: angle_ceiling <= cfg_data[15:0];
          default: ;
        endcase
      end

      // In S_DONE the output register is handled by the state itself.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            was_v   <= measure_voltage;
            ph      <= phase_counter;
            work    <= square_sum;
            rem     <= '0;
            step    <= '0;
            divisor <= (sample_count == 16'd0) ? 16'd1 : sample_count;
            state   <= S_DIV;
          end
        end
        S_DIV, S_DIV_ERR: begin
          // One restoring division step per cycle.
          work <= {work[38:0], sub_ge};
          if (state == S_DIV && step == SUM_STEPS_LAST) begin
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_SQRT;
          end else begin
            rem  <= {5'd0, sub_ge ? sub_diff[15:0] : sub_a[15:0]};
            step <= step + 6'd1;
            if (state == S_DIV_ERR && step == ERR_STEPS_LAST) begin
              state <= S_ANGLE;
            end
          end
        end
        S_SQRT: begin
          // One result bit per cycle, two radicand bits consumed.
          rem  <= sub_ge ? sub_diff[20:0] : sub_a[20:0];
          root <= {root[18:0], sub_ge};
          work <= {work[37:0], 2'b00};
          step <= step + 6'd1;
          if (step == ROOT_STEPS_LAST) begin
            state <= S_MUL_RMS;
          end
        end
        S_MUL_RMS: begin
          prod  <= mul_a * mul_b;
          state <= S_RMS;
        end
        S_RMS: begin
          rms <= rms_sat;
          if (was_v) begin
            state <= S_MUL_PWR;
          end else begin
            current_rms[ph] <= rms_sat;
            measure_voltage <= 1'b1;
            pp              <= '0;
            state           <= S_DONE;
          end
        end
        S_MUL_PWR: begin
          prod  <= mul_a * mul_b;
          state <= S_PWR;
        end
        S_PWR: begin
          pp               <= pp_sat;
          phase_powers[ph] <= pp_sat;
          state            <= S_ERR;
        end
        S_ERR: begin
          if (target == 16'd0) begin
            angle_acc <= (angle_floor >= OFF_DELTA_V) ? angle_floor - OFF_DELTA_V : 16'd0;
            state     <= S_WRAP;
          end else begin
            err_neg <= err[18];
            work    <= {err_mag, 22'd0};
            rem     <= '0;
            step    <= '0;
            divisor <= (loop_lag == 16'd0) ? 16'd1 : loop_lag;
            state   <= S_DIV_ERR;
          end
        end
        S_ANGLE: begin
          angle_acc <= angle_clamped;
          state     <= S_WRAP;
        end
        S_WRAP: begin
          measure_voltage <= 1'b0;
          if (ph == LAST_PHASE) begin
            phase_counter <= 2'd0;
            power_average <= avg_sat;
          end else begin
            phase_counter <= ph + 2'd1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            was_voltage     <= was_v;
            phase_index     <= ph;
            rms_value       <= rms;
            phase_power     <= pp;
            total_power     <= total;
            fire_angle      <= angle_acc;
            average_power   <= power_average;
            next_is_voltage <= measure_voltage;
            next_phase      <= phase_counter;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/tppr_checker.sv */
// ----------------------------------------------------------------------------
// tppr_checker
// Port-level checks of the three-phase power regulator.
// ----------------------------------------------------------------------------
module tppr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          was_voltage,
  input logic [1:0]                    phase_index,
  input logic [tppr_pkg::VAL_W-1:0]    rms_value,
  input logic [tppr_pkg::VAL_W-1:0]    phase_power,
  input logic                          next_is_voltage,
  input logic [1:0]                    next_phase
);

  localparam logic [1:0] LAST_PHASE = 2'(tppr_pkg::PHASES - 1);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rms_value) && $stable(phase_power))
    else $error("stalled result changed");

  // The block works on one window at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second window accepted while busy");

  // A current window is followed by the voltage window of the same phase.
  a_current_then_voltage: assert property (@(posedge clk) disable iff (rst)
    out_valid && !was_voltage |-> next_is_voltage && next_phase == phase_index
                                  && phase_power == '0)
    else $error("current window result inconsistent");

  // A voltage window moves on to the current window of the next phase.
  a_voltage_advances: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_voltage |-> !next_is_voltage &&
      ((phase_index == LAST_PHASE && next_phase == 2'd0) ||
       (phase_index != LAST_PHASE && next_phase == phase_index + 2'd1)))
    else $error("phase rotation broken");

endmodule

bind three_phase_power_regulator_unit tppr_checker u_tppr_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .was_voltage     (was_voltage),
  .phase_index     (phase_index),
  .rms_value       (rms_value),
  .phase_power     (phase_power),
  .next_is_voltage (next_is_voltage),
  .next_phase      (next_phase)
);
